// ===== hw/rtl/ioem_pkg.sv =====
// Package with shared constants, types and the exponential table for the overlap mean core.
`default_nettype none
package ioem_pkg;
    localparam int MaxSegments   = 256;
    localparam int ExpTableDepth = 1024;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_INV  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [0:0] CFG_DIR    = 1'd0;
    localparam logic [0:0] CFG_CUTOFF = 1'd1;

    localparam logic [23:0] SumMax = 24'hFFFFFF;

    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [16:0] divisor;
    } t_div_req;

    // Long division by shift and subtract, used only while the table is built.
    function automatic longint unsigned floor_div(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        begin
            q = 0;
            r = 0;
            for (int b = 63; b >= 0; b--) begin
                r = (r << 1) | ((num >> b) & 64'd1);
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 64'd1;
                end
            end
            floor_div = q;
        end
    endfunction

    // Entry i holds 4096*exp(-8 + 16*i/depth) in Q12.12, saturated to 24 bits.
    function automatic logic [23:0] exp_entry(input longint unsigned i,
                                              input longint unsigned depth);
        longint y;
        logic neg;
        longint unsigned mag;
        longint unsigned term;
        longint sum;
        longint unsigned v;
        begin
            y = longint'(floor_div(i << 30, depth)) - (longint'(1) << 29);
            neg = (y < 0);
            mag = neg ? longint'(-y) : longint'(y);
            term = 64'd1 << 30;
            sum = longint'(term);
            for (int k = 1; k <= 14; k++) begin
                term = floor_div((term * mag) >> 30, 64'(k));
                if (neg && (k % 2 == 1)) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            v = (longint'(sum) + 512) >> 10;
            for (int s = 0; s < 4; s++) v = (v * v + (64'd1 << 19)) >> 20;
            v = (v + 128) >> 8;
            exp_entry = (v > 64'hFFFFFF) ? SumMax : v[23:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ioem_div.sv =====
// Restoring divider with rounding: one quotient bit per cycle.
`default_nettype none
module ioem_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ioem_pkg::t_div_req i_req,
    output logic                   o_done,
    output logic [23:0]            o_quot
);
    import ioem_pkg::*;
    logic [47:0] r_num, n_num;
    logic [17:0] r_rem, n_rem;
    logic [16:0] r_den, n_den;
    logic [47:0] r_q, n_q;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [17:0] trial;

    always_comb begin
        n_num = r_num; n_rem = r_rem; n_den = r_den; n_q = r_q;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        trial = {r_rem[16:0], r_num[47]} - {1'b0, r_den};
        if (i_req.start) begin
            n_num  = i_req.dividend + {32'd0, 16'(i_req.divisor >> 1)};
            n_den  = i_req.divisor;
            n_rem  = '0; n_q = '0; n_cnt = 6'd48; n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[46:0], 1'b0};
            if (!trial[17]) begin
                n_rem = trial; n_q = {r_q[46:0], 1'b1};
            end else begin
                n_rem = {r_rem[16:0], r_num[47]}; n_q = {r_q[46:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_num <= n_num; r_rem <= n_rem; r_den <= n_den; r_q <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = (r_q[47:24] != 24'd0) ? SumMax : r_q[23:0];
endmodule
`default_nettype wire

// ===== hw/rtl/interval_overlap_exp_mean_core.sv =====
// Top level of the segment overlap mean-of-exponentials core.
//
// Channel  Direction  Handshake          Beat contents
// in       sink       i_valid/o_stall    mode, segment bounds and value, query position
// out      source     o_valid/i_stall    summary value, echoed position, status
// cfg      sink       i_cfg_we           register index and data
//
// A clear or load beat is answered in the cycle after it is taken. A query reads one segment
// per cycle, drains a three-stage compare, table and add pipeline, then runs 48 divider
// steps when a division is needed.
// Reset is synchronous and active low; it empties the store and clears both registers.
// While a result is stalled at the output no new beat is taken.
`default_nettype none
module interval_overlap_exp_mean_core #(
    parameter int MAX_SEGMENTS    = ioem_pkg::MaxSegments,
    parameter int EXP_TABLE_DEPTH = ioem_pkg::ExpTableDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_seg_start,
    input  wire logic [31:0] i_seg_end,
    input  wire logic signed [15:0] i_seg_value,
    input  wire logic [31:0] i_query_pos,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [23:0]      o_summary_value,
    output logic [31:0]      o_result_pos,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import ioem_pkg::*;

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int TW = $clog2(EXP_TABLE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DRAIN = 3'd2,
                           S_DIV = 3'd3;

    // Segment store: undefined until written, reads registered.
    logic [31:0] mem_s [MAX_SEGMENTS];
    logic [31:0] mem_e [MAX_SEGMENTS];
    logic [15:0] mem_v [MAX_SEGMENTS];
    logic [23:0] rom   [EXP_TABLE_DEPTH];
    logic [31:0] r_rd_s, r_rd_e;
    logic [15:0] r_rd_v;

    logic [2:0]  r_state;
    logic [CW-1:0] r_count, r_idx;
    logic        r_rd_vld, r_p_vld;
    logic        r_dir;
    logic signed [15:0] r_cutoff;
    logic [31:0] r_pos;
    logic [47:0] r_acc;
    logic [16:0] r_cov;
    logic        r_passed, r_bad;
    logic [TW-1:0] r_tidx;
    logic        r_hit;
    logic [23:0] r_rom_q;
    logic        r_add;
    logic        drained;
    t_div_req    div_req;
    logic        div_done;
    logic [23:0] div_q;

    always_comb begin
        for (int k = 0; k < EXP_TABLE_DEPTH; k++)
            rom[k] = exp_entry(longint'(k), longint'(EXP_TABLE_DEPTH));
    end

    assign o_stall = (r_state != S_IDLE) || o_valid;

    // The scan pipeline is empty once no read, compare or add is still on its way.
    assign drained = !r_rd_vld && !r_p_vld && !r_hit && !r_add;

    // Stage one: compare the fetched segment; stage two: table read; the add follows it.
    logic signed [16:0] adj;
    logic [16:0] biased;
    logic [16+TW:0] prod;
    logic covers, inv;
    always_comb begin
        adj    = r_dir ? -17'(signed'(r_rd_v)) : 17'(signed'(r_rd_v));
        biased = 17'(adj + 17'sd32768);
        prod   = (16+TW+1)'(biased) * (16+TW+1)'(EXP_TABLE_DEPTH);
        inv    = r_rd_s > r_rd_e;
        covers = (r_rd_s <= r_pos) && (r_pos <= r_rd_e);
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall && i_mode == MODE_LOAD && r_count < CW'(MAX_SEGMENTS)) begin
            mem_s[r_count[AW-1:0]] <= i_seg_start;
            mem_e[r_count[AW-1:0]] <= i_seg_end;
            mem_v[r_count[AW-1:0]] <= i_seg_value;
        end
        r_rd_s <= mem_s[r_idx[AW-1:0]];
        r_rd_e <= mem_e[r_idx[AW-1:0]];
        r_rd_v <= mem_v[r_idx[AW-1:0]];
        r_tidx <= (prod[16+TW:16] >= (TW+1)'(EXP_TABLE_DEPTH)) ?
                  TW'(EXP_TABLE_DEPTH - 1) : prod[TW+15:16];
        r_rom_q <= rom[r_tidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_idx <= '0; r_dir <= 1'b0;
            r_cutoff <= '0; o_valid <= 1'b0; r_rd_vld <= 1'b0; r_p_vld <= 1'b0;
            r_hit <= 1'b0; r_add <= 1'b0; div_req.start <= 1'b0;
        end else begin
            div_req.start <= (r_state == S_DRAIN) && drained && !r_bad && r_passed &&
                             (r_cov != 17'd0);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DIR:    r_dir <= i_cfg_data[0];
                    CFG_CUTOFF: r_cutoff <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (o_valid && !i_stall) o_valid <= 1'b0;
            r_rd_vld <= (r_state == S_SCAN) && (r_idx < r_count);
            r_p_vld  <= r_rd_vld;
            r_hit    <= r_rd_vld && !r_bad && !inv && covers && (adj > 17'(r_cutoff));
            r_add    <= r_hit;
            if (r_rd_vld && !r_bad) begin
                if (inv) r_bad <= 1'b1;
                else if (covers) r_cov <= r_cov + 17'd1;
            end
            if (r_add) begin
                r_acc <= r_acc + 48'(r_rom_q);
                r_passed <= 1'b1;
            end
            case (r_state)
                S_IDLE: if (i_valid && !o_stall) begin
                    o_summary_value <= '0; o_result_pos <= '0;
                    o_status <= (i_mode == MODE_LOAD && r_count >= CW'(MAX_SEGMENTS)) ?
                                ST_FULL : ST_OK;
                    case (i_mode)
                        MODE_CLEAR: begin r_count <= '0; o_valid <= 1'b1; end
                        MODE_LOAD: begin
                            if (r_count < CW'(MAX_SEGMENTS)) r_count <= r_count + CW'(1);
                            o_valid <= 1'b1;
                        end
                        MODE_QUERY: begin
                            r_pos <= i_query_pos; r_idx <= '0; r_acc <= '0;
                            r_cov <= '0; r_passed <= 1'b0; r_bad <= 1'b0;
                            r_state <= S_SCAN;
                        end
                        default: o_valid <= 1'b1;
                    endcase
                end
                S_SCAN: begin
                    if (r_idx < r_count) r_idx <= r_idx + CW'(1);
                    else r_state <= S_DRAIN;
                end
                S_DRAIN: if (drained) begin
                    o_result_pos <= r_pos;
                    if (r_bad) begin
                        o_status <= ST_INV; o_valid <= 1'b1; r_state <= S_IDLE;
                    end else if (!r_passed || r_cov == 17'd0) begin
                        o_valid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: if (div_done) begin
                    o_summary_value <= div_q; o_valid <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
        div_req.dividend <= r_acc;
        div_req.divisor  <= r_cov;
    end

    ioem_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_q)
    );
endmodule
`default_nettype wire
